@@ hdl/bpa_pkg.sv @@
// Package for the block pool allocator: field widths, limits, codes and item types.
package bpa_pkg;

   // Field widths of a block handle and of the chunk size register
   localparam int CHUNK_W = 6;
   localparam int BLOCK_W = 17;
   localparam int BPC_W   = 18;

   // Pool limits that the handle widths settle
   localparam int MAX_CHUNKS = 64;
   localparam int MAX_BLOCKS = 131072;
   localparam int CHUNKS_W   = $clog2(MAX_CHUNKS + 1);

   // Reset value of the chunk size register
   localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(MAX_BLOCKS);

   // Request operation
   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } bpa_op_type;

   // Result status
   typedef enum logic [2:0] {
      ST_REUSED   = 3'd0,
      ST_FRESH    = 3'd1,
      ST_NOMEM    = 3'd2,
      ST_STORED   = 3'd3,
      ST_BADCHUNK = 3'd4,
      ST_FULL     = 3'd5
   } bpa_status_type;

   // One free stack entry
   typedef struct packed {
      logic [CHUNK_W-1:0] chunk;
      logic [BLOCK_W-1:0] block;
   } bpa_entry_type;

endpackage

@@ hdl/bpa_ifs.sv @@
// Valid/ready channel interfaces for the request and result items of the allocator.
interface bpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [bpa_pkg::CHUNK_W-1:0] chunk_in;
   logic [bpa_pkg::BLOCK_W-1:0] block_in;

   modport source (output valid, output op, output chunk_in, output block_in, input ready);
   modport sink   (input valid, input op, input chunk_in, input block_in, output ready);
endinterface

interface bpa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bpa_pkg::CHUNK_W-1:0] chunk_out;
   logic [bpa_pkg::BLOCK_W-1:0] block_out;
   logic [2:0]                  status;

   modport source (output valid, output chunk_out, output block_out, output status,
                   input ready);
   modport sink   (input valid, input chunk_out, input block_out, input status,
                   output ready);
endinterface

@@ hdl/block_pool_allocator.sv @@
// Block pool allocator: free stack of returned handles plus a bump allocator over chunks.
//
// Each request item (get or put) gives exactly one result item. An item is taken
// into an input register, handled there, and its result goes to an output
// register, so the block takes one item per cycle while results are being taken.
// The result is held in the output register until it is taken; a stalled
// result holds the input register and the input side stalls with it, since an
// item moves on only when the output register is free. The free stack lives
// in a single-write, single-read memory whose next top entry is read every cycle,
// with the value just pushed bypassed around the memory, so pops and pushes may
// follow each other in any order in back-to-back cycles. A get pops the last
// returned handle; with the stack empty it grants the next fresh block of the
// current chunk, opening a new chunk once as many blocks as the chunk size
// register holds have been handed out, and reports no memory once all chunks are
// open. A put is stored only for a chunk already opened and while the stack has
// room. The user writes the chunk size register via csr_wr_en/csr_wr_data only while
// idle, not enforced by the block; 0 acts as 1 and values above the block limit act
// as the limit. Stack entries need no reset clearing: only pushed ones are popped.
module block_pool_allocator #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   bpa_req_if.sink                   req_ch,
   bpa_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [bpa_pkg::BPC_W-1:0] csr_wr_data
);
   import bpa_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // Input register
   logic               stg_valid_ff;
   bpa_op_type         stg_op_ff;
   logic [CHUNK_W-1:0] stg_chunk_ff;
   logic [BLOCK_W-1:0] stg_block_ff;

   // Allocator state
   logic [BPC_W-1:0]    bpc_ff, bpc_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CHUNKS_W-1:0] chunks_open_ff, chunks_open_in;
   logic [CHUNK_W-1:0]  cur_chunk_ff, cur_chunk_in;
   logic [BPC_W-1:0]    next_block_ff, next_block_in;

   // Free stack memory with top-of-stack bypass
   bpa_entry_type       stack_mem [STACK_DEPTH];
   bpa_entry_type       rd_data_ff;
   logic                byp_valid_ff;
   bpa_entry_type       byp_data_ff;
   bpa_entry_type       top_entry;
   bpa_entry_type       push_data;
   logic                push_en;
   logic [CNT_W-1:0]    cnt_dec;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;

   // Output register
   logic               rsp_valid_ff;
   logic [CHUNK_W-1:0] rsp_chunk_ff, rsp_chunk_in;
   logic [BLOCK_W-1:0] rsp_block_ff, rsp_block_in;
   bpa_status_type     rsp_status_ff, rsp_status_in;

   logic advance;

   // Handshake: the staged item moves on when the output register is free
   assign advance      = stg_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !stg_valid_ff || advance;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.chunk_out = rsp_chunk_ff;
   assign rsp_ch.block_out = rsp_block_ff;
   assign rsp_ch.status    = rsp_status_ff;

   // Clamp the chunk size as it is written
   always_comb begin
      bpc_in = bpc_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            bpc_in = BPC_W'(1);
         end else if (csr_wr_data > BPC_W'(MAX_BLOCKS)) begin
            bpc_in = BPC_W'(MAX_BLOCKS);
         end else begin
            bpc_in = csr_wr_data;
         end
      end
   end

   // Current top of stack: the value just pushed, else the prefetched entry
   assign top_entry = byp_valid_ff ? byp_data_ff : rd_data_ff;

   // Request handling
   always_comb begin
      count_in       = count_ff;
      chunks_open_in = chunks_open_ff;
      cur_chunk_in   = cur_chunk_ff;
      next_block_in  = next_block_ff;
      push_en        = 1'b0;
      push_data      = '{chunk: stg_chunk_ff, block: stg_block_ff};
      rsp_chunk_in   = '0;
      rsp_block_in   = '0;
      rsp_status_in  = ST_STORED;
      if (advance) begin
         unique case (stg_op_ff)
            OP_GET: begin
               priority if (count_ff != '0) begin
                  // reuse the most recently returned handle
                  count_in      = count_ff - CNT_W'(1);
                  rsp_chunk_in  = top_entry.chunk;
                  rsp_block_in  = top_entry.block;
                  rsp_status_in = ST_REUSED;
               end else if (next_block_ff >= bpc_ff) begin
                  if (chunks_open_ff >= CHUNKS_W'(MAX_CHUNKS)) begin
                     rsp_status_in = ST_NOMEM;
                  end else begin
                     // open a new chunk and grant its first block
                     cur_chunk_in   = chunks_open_ff[CHUNK_W-1:0];
                     chunks_open_in = chunks_open_ff + CHUNKS_W'(1);
                     next_block_in  = BPC_W'(1);
                     rsp_chunk_in   = chunks_open_ff[CHUNK_W-1:0];
                     rsp_block_in   = '0;
                     rsp_status_in  = ST_FRESH;
                  end
               end else begin
                  // bump within the current chunk
                  next_block_in = next_block_ff + BPC_W'(1);
                  rsp_chunk_in  = cur_chunk_ff;
                  rsp_block_in  = next_block_ff[BLOCK_W-1:0];
                  rsp_status_in = ST_FRESH;
               end
            end
            OP_PUT: begin
               priority if ({1'b0, stg_chunk_ff} >= chunks_open_ff) begin
                  rsp_status_in = ST_BADCHUNK;
               end else if (count_ff == CNT_W'(STACK_DEPTH)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  push_en       = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rsp_status_in = ST_STORED;
               end
            end
         endcase
      end
   end

   // Memory addresses: write at the count, prefetch the entry under the next count
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign cnt_dec = count_in - CNT_W'(1);
   assign rd_addr = cnt_dec[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[wr_addr] <= push_data;
      end
      rd_data_ff  <= stack_mem[rd_addr];
      byp_data_ff <= push_data;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byp_valid_ff   <= 1'b0;
         bpc_ff         <= BPC_RESET;
         count_ff       <= '0;
         chunks_open_ff <= CHUNKS_W'(1);
         cur_chunk_ff   <= '0;
         next_block_ff  <= '0;
      end else begin
         stg_valid_ff   <= req_ch.valid || (stg_valid_ff && !advance);
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         byp_valid_ff   <= push_en;
         bpc_ff         <= bpc_in;
         count_ff       <= count_in;
         chunks_open_ff <= chunks_open_in;
         cur_chunk_ff   <= cur_chunk_in;
         next_block_ff  <= next_block_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         stg_op_ff    <= bpa_op_type'(req_ch.op);
         stg_chunk_ff <= req_ch.chunk_in;
         stg_block_ff <= req_ch.block_in;
      end
      if (advance) begin
         rsp_chunk_ff  <= rsp_chunk_in;
         rsp_block_ff  <= rsp_block_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("free stack count above depth");

   a_chunks_bound: assert property (@(posedge clock) disable iff (reset)
      chunks_open_ff != '0 && chunks_open_ff <= CHUNKS_W'(MAX_CHUNKS))
      else $error("chunks_open out of range");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      advance && stg_op_ff == OP_GET && count_ff != '0
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not lower the stack count");

   a_fresh_in_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FRESH
      |-> {1'b0, rsp_block_ff} < bpc_ff)
      else $error("fresh block beyond chunk size");

   a_cur_chunk_open: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cur_chunk_ff} < chunks_open_ff)
      else $error("current chunk not opened");

endmodule

@@ bench/block_pool_allocator_tb.sv @@
// Testbench for block_pool_allocator: directed and random get/put traffic against a predictor.
`timescale 1ns / 1ps

module block_pool_allocator_tb;
   import bpa_pkg::*;

   localparam int STACK_DEPTH  = 1024;
   localparam int LIMIT_CYCLES = 400000;

   // One result item as the allocator should answer it
   typedef struct packed {
      logic [CHUNK_W-1:0] chunk;
      logic [BLOCK_W-1:0] block;
      bpa_status_type     status;
   } grant_item_type;

   // Predicts every grant and checks returned items in order
   class pool_scoreboard;
      bpa_entry_type    free_list[STACK_DEPTH];
      int unsigned      free_count;
      int unsigned      chunks_open;
      int unsigned      cur_chunk;
      int unsigned      next_block;
      logic [BPC_W-1:0] blk_limit;
      grant_item_type   pending_grants[$];
      int               errors;
      int               requests;
      int               status_seen[6];

      function new();
         free_count  = 0;
         chunks_open = 1;
         cur_chunk   = 0;
         next_block  = 0;
         blk_limit   = BPC_RESET;
         errors      = 0;
         requests    = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Work out the grant for one accepted request item
      function void note_request(bpa_op_type op, logic [CHUNK_W-1:0] c,
                                 logic [BLOCK_W-1:0] b);
         grant_item_type r;
         int unsigned    lim;
         r.chunk = '0;
         r.block = '0;
         // zero acts as one, oversize acts as the block limit
         lim = blk_limit;
         if (blk_limit == 0) begin
            lim = 1;
         end
         if (blk_limit > MAX_BLOCKS) begin
            lim = MAX_BLOCKS;
         end
         requests++;
         if (op == OP_GET) begin
            if (free_count > 0) begin
               free_count--;
               r.chunk  = free_list[free_count].chunk;
               r.block  = free_list[free_count].block;
               r.status = ST_REUSED;
            end else if (next_block >= lim && chunks_open >= MAX_CHUNKS) begin
               r.status = ST_NOMEM;
            end else begin
               if (next_block >= lim) begin
                  cur_chunk = chunks_open;
                  chunks_open++;
                  next_block = 0;
               end
               r.chunk  = CHUNK_W'(cur_chunk);
               r.block  = BLOCK_W'(next_block);
               r.status = ST_FRESH;
               next_block++;
            end
         end else if (c >= chunks_open) begin
            r.status = ST_BADCHUNK;
         end else if (free_count >= STACK_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            free_list[free_count] = {c, b};
            free_count++;
            r.status = ST_STORED;
         end
         pending_grants.push_back(r);
      endfunction

      // Compare one returned item with the oldest prediction
      function void check_result(logic [CHUNK_W-1:0] c, logic [BLOCK_W-1:0] b,
                                 logic [2:0] s);
         grant_item_type e;
         if (!$isunknown(s) && s <= ST_FULL) begin
            status_seen[s]++;
         end
         if (pending_grants.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: unexpected item chunk %0d block %0d status %0d",
                        $realtime, c, b, s);
            end
         end else begin
            e = pending_grants.pop_front();
            if (c !== e.chunk || b !== e.block || s !== e.status) begin
               errors++;
               if (errors <= 10) begin
                  $display({"%0t: mismatch: expected chunk %0d block %0d status %0d,",
                            " got %0d %0d %0d"},
                           $realtime, e.chunk, e.block, e.status, c, b, s);
               end
            end
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [BPC_W-1:0] csr_wr_data;
   bit               req_burst;
   bit               rsp_burst;
   int               cycles = 0;
   pool_scoreboard   sb;

   bpa_req_if req_if ();
   bpa_rsp_if rsp_if ();

   block_pool_allocator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one request item and note it once the allocator takes it
   task automatic send_request(bpa_op_type op, logic [CHUNK_W-1:0] c, logic [BLOCK_W-1:0] b);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.chunk_in <= c;
      req_if.block_in <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(op, c, b);
   endtask

   // Change chunk size once every grant is back and the pipe has emptied
   task automatic write_blk_limit(logic [BPC_W-1:0] v);
      while (sb.pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.blk_limit = v;
   endtask

   // Random traffic under one chunk size; puts mostly name an opened chunk
   task automatic random_phase(logic [BPC_W-1:0] v, int n, int put_pct);
      logic [CHUNK_W-1:0] c;
      logic [BLOCK_W-1:0] b;
      write_blk_limit(v);
      for (int i = 0; i < n; i++) begin
         if (i % 32 == 0) begin
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 99) < put_pct) begin
            if ($urandom_range(0, 3) != 0) begin
               c = CHUNK_W'($urandom_range(0, sb.chunks_open - 1));
            end else begin
               c = CHUNK_W'($urandom);
            end
            case ($urandom_range(0, 7))
               0: b = '0;
               1: b = '1;
               default: b = BLOCK_W'($urandom);
            endcase
            send_request(OP_PUT, c, b);
         end else begin
            send_request(OP_GET, CHUNK_W'($urandom), BLOCK_W'($urandom));
         end
      end
      req_if.valid <= 1'b0;
   endtask

   // Result side: random stalls, check each item taken
   initial begin : rsp_sink
      int stall;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         sb.check_result(rsp_if.chunk_out, rsp_if.block_out, rsp_if.status);
      end
   end

   // Main sequence
   initial begin
      sb = new();
      req_if.valid    <= 1'b0;
      req_if.op       <= OP_GET;
      req_if.chunk_in <= '0;
      req_if.block_in <= '0;
      rsp_if.ready    <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      reset           <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fresh grants at reset size, bad chunks, stack reuse in LIFO order
      send_request(OP_GET, '1, '1);
      send_request(OP_GET, '0, '0);
      send_request(OP_PUT, 6'd1, 17'd5);
      send_request(OP_PUT, 6'd63, 17'd131071);
      send_request(OP_PUT, 6'd0, 17'd131071);
      send_request(OP_PUT, 6'd0, 17'd0);
      send_request(OP_GET, 6'd0, 17'd0);
      send_request(OP_GET, 6'd0, 17'd0);
      send_request(OP_GET, 6'd0, 17'd0);
      req_if.valid <= 1'b0;

      // size zero acts as one; lowered below next_block opens a new chunk
      write_blk_limit('0);
      send_request(OP_GET, 6'd0, 17'd0);
      send_request(OP_GET, 6'd0, 17'd0);
      send_request(OP_PUT, 6'd2, 17'd77);
      send_request(OP_PUT, 6'd3, 17'd1);
      send_request(OP_GET, 6'd0, 17'd0);
      req_if.valid <= 1'b0;

      // all ones clamps to the block limit
      write_blk_limit('1);
      send_request(OP_GET, 6'd0, 17'd0);
      send_request(OP_PUT, 6'd1, 17'h15555);
      send_request(OP_GET, 6'd0, 17'd0);
      req_if.valid <= 1'b0;

      // small chunk rolls over quickly
      write_blk_limit(18'd3);
      repeat (4) send_request(OP_GET, 6'd0, 17'd0);
      send_request(OP_PUT, 6'd3, 17'd131071);
      send_request(OP_GET, 6'd0, 17'd0);
      req_if.valid <= 1'b0;

      // random part: large and tiny sizes in turn, a long put-heavy phase to fill the stack, then size 7
      random_phase(BPC_RESET, 50, 50);
      random_phase(18'd5, 50, 45);
      random_phase('1, 40, 50);
      random_phase(18'd2, 70, 25);
      random_phase(18'd1, 60, 20);
      random_phase('0, 1060, 99);
      random_phase(18'd7, 40, 50);

      while (sb.pending_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests: %0d reused, %0d fresh, %0d out of memory",
               sb.requests, sb.status_seen[ST_REUSED], sb.status_seen[ST_FRESH],
               sb.status_seen[ST_NOMEM]);
      $display("puts: %0d stored, %0d bad chunk, %0d stack full; %0d mismatches",
               sb.status_seen[ST_STORED], sb.status_seen[ST_BADCHUNK],
               sb.status_seen[ST_FULL], sb.errors);
      if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
